// File: design/pte_pkg.sv
// Shared types, codes and sizes for the palette tint engine.
package pte_pkg;

   localparam int unsigned DEF_PALETTE_ROWS     = 12;
   localparam int unsigned DEF_CLUTS_PER_ROW    = 16;
   localparam int unsigned DEF_COLOURS_PER_CLUT = 16;

   localparam int unsigned FUNC_W      = 2;
   localparam int unsigned ADDR_FLD_W  = 12;
   localparam int unsigned COLOUR_W    = 16;
   localparam int unsigned CHAN_W      = 5;
   localparam int unsigned OFFSET_W    = 6;
   localparam int unsigned ROW_MASK_W  = 12;
   localparam int unsigned CLUT_MASK_W = 16;
   localparam int unsigned SEL_IDX_W   = 4;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 5'd31;
   localparam logic [CHAN_W-1:0] CHAN_MIN = 5'd1;

   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_APPLY = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_ROW_MASK   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CLUT_MASK  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RED_OFS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GREEN_OFS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BLUE_OFS   = 3'd4;

   typedef struct packed {
      logic signed [OFFSET_W-1:0] red;
      logic signed [OFFSET_W-1:0] green;
      logic signed [OFFSET_W-1:0] blue;
   } tint_offsets_type;

endpackage

// File: design/pte_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pte_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 3072,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/pte_tint.sv
// Per-channel tint: offset add with clamp to 1..31, zero channels and flag kept.
module pte_tint (
   input  logic [pte_pkg::COLOUR_W-1:0] src_word,
   input  pte_pkg::tint_offsets_type    offsets,
   output logic [pte_pkg::COLOUR_W-1:0] tinted_word
);
   import pte_pkg::*;

   function automatic logic [CHAN_W-1:0] tint_chan(input logic [CHAN_W-1:0] c,
                                                   input logic signed [OFFSET_W-1:0] ofs);
      logic signed [CHAN_W+1:0] sum;
      logic [CHAN_W-1:0]        res;
      sum = $signed({2'b00, c}) + (CHAN_W+2)'(ofs);
      if (c == '0) begin
         res = '0;
      end else if (sum < $signed((CHAN_W+2)'(CHAN_MIN))) begin
         res = CHAN_MIN;
      end else if (sum > $signed((CHAN_W+2)'(CHAN_MAX))) begin
         res = CHAN_MAX;
      end else begin
         res = sum[CHAN_W-1:0];
      end
      return res;
   endfunction

   assign tinted_word = {src_word[COLOUR_W-1],
                         tint_chan(src_word[3*CHAN_W-1:2*CHAN_W], offsets.blue),
                         tint_chan(src_word[2*CHAN_W-1:CHAN_W], offsets.green),
                         tint_chan(src_word[CHAN_W-1:0], offsets.red)};

endmodule

// File: design/palette_tint_engine.sv
// Palette tint engine top level: source and tinted stores, walk sequencer, word ports.
// Path from accept to rsp_valid: write or ignored word via FIN, read via READ and FIN, apply via
// WALK, DRAIN and FIN. Walk: an unselected row is skipped whole, a selected row other than row 0
// is tinted in every CLUT; on row 0 only the CLUTs selected in the CLUT mask are tinted.
// A new word is taken only in IDLE, after FIN has passed the last result on; a stalled result holds.
// Reset (synchronous) clears control, registers and the dirty flag; stores are not cleared.
module palette_tint_engine #(
   parameter int unsigned PALETTE_ROWS     = pte_pkg::DEF_PALETTE_ROWS,
   parameter int unsigned CLUTS_PER_ROW    = pte_pkg::DEF_CLUTS_PER_ROW,
   parameter int unsigned COLOURS_PER_CLUT = pte_pkg::DEF_COLOURS_PER_CLUT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [pte_pkg::FUNC_W-1:0]        req_func,
   input  logic [pte_pkg::ADDR_FLD_W-1:0]    req_entry_address,
   input  logic [pte_pkg::COLOUR_W-1:0]      req_colour_word,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pte_pkg::COLOUR_W-1:0]      rsp_read_colour,
   output logic                              rsp_tinted_dirty,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pte_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pte_pkg::CSR_DATA_W-1:0]    csr_data
);
   import pte_pkg::*;

   localparam int unsigned DEPTH = PALETTE_ROWS * CLUTS_PER_ROW * COLOURS_PER_CLUT;
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned RW = (PALETTE_ROWS > 1) ? $clog2(PALETTE_ROWS) : 1;
   localparam int unsigned CW = (CLUTS_PER_ROW > 1) ? $clog2(CLUTS_PER_ROW) : 1;
   localparam int unsigned KW = (COLOURS_PER_CLUT > 1) ? $clog2(COLOURS_PER_CLUT) : 1;
   localparam logic [AW-1:0] ROW_STEP  = AW'(CLUTS_PER_ROW * COLOURS_PER_CLUT);
   localparam logic [AW-1:0] CLUT_STEP = AW'(COLOURS_PER_CLUT);
   localparam logic [RW-1:0] LAST_ROW  = RW'(PALETTE_ROWS - 1);
   localparam logic [CW-1:0] LAST_CLUT = CW'(CLUTS_PER_ROW - 1);
   localparam logic [KW-1:0] LAST_COL  = KW'(COLOURS_PER_CLUT - 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_READ  = 5'b00010,
      ST_WALK  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_FIN   = 5'b10000
   } state_type;

   state_type                state_ff, state_in;
   logic [RW-1:0]            row_ff, row_in;
   logic [CW-1:0]            clut_ff, clut_in;
   logic [KW-1:0]            col_ff, col_in;
   logic [AW-1:0]            addr_ff, addr_in;
   logic                     pend_ff, pend_in;
   logic [AW-1:0]            pend_addr_ff, pend_addr_in;
   logic                     rd_ok_ff, rd_ok_in;
   logic [COLOUR_W-1:0]      res_colour_ff, res_colour_in;
   logic                     dirty_ff, dirty_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [COLOUR_W-1:0]      rsp_colour_ff, rsp_colour_in;
   logic                     rsp_dirty_ff, rsp_dirty_in;
   logic [ROW_MASK_W-1:0]    row_mask_ff, row_mask_in;
   logic [CLUT_MASK_W-1:0]   clut_mask_ff, clut_mask_in;
   tint_offsets_type         offsets_ff, offsets_in;

   logic                     req_fire;
   logic                     in_range;
   logic [AW-1:0]            req_addr;
   logic                     src_we, src_re;
   logic                     tint_re;
   logic [COLOUR_W-1:0]      src_rdata, tint_rdata, tinted_word;
   logic [SEL_IDX_W-1:0]     row_idx, clut_idx;
   logic [CLUT_MASK_W-1:0]   row_mask_wide;
   logic                     row_ok, clut_ok;
   logic                     end_row, end_clut, end_col;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign in_range  = ({20'd0, req_entry_address} < 32'(DEPTH));
   assign req_addr  = AW'(req_entry_address);

   assign src_we  = req_fire && (req_func == FUNC_WRITE) && in_range;
   assign tint_re = req_fire && (req_func == FUNC_READ) && in_range;

   assign row_idx       = SEL_IDX_W'(row_ff);
   assign clut_idx      = SEL_IDX_W'(clut_ff);
   assign row_mask_wide = {(CLUT_MASK_W - ROW_MASK_W)'(0), row_mask_ff};
   assign row_ok        = row_mask_wide[row_idx];
   assign clut_ok       = (row_ff != '0) || clut_mask_ff[clut_idx];
   assign end_row       = (row_ff == LAST_ROW);
   assign end_clut      = (clut_ff == LAST_CLUT);
   assign end_col       = (col_ff == LAST_COL);

   pte_ram #(.WIDTH(COLOUR_W), .DEPTH(DEPTH)) u_src_ram (
      .clock   (clock),
      .wr_en   (src_we),
      .wr_addr (req_addr),
      .wr_data (req_colour_word),
      .rd_en   (src_re),
      .rd_addr (addr_ff),
      .rd_data (src_rdata)
   );

   pte_tint u_tint (
      .src_word    (src_rdata),
      .offsets     (offsets_ff),
      .tinted_word (tinted_word)
   );

   pte_ram #(.WIDTH(COLOUR_W), .DEPTH(DEPTH)) u_tint_ram (
      .clock   (clock),
      .wr_en   (pend_ff),
      .wr_addr (pend_addr_ff),
      .wr_data (tinted_word),
      .rd_en   (tint_re),
      .rd_addr (req_addr),
      .rd_data (tint_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      clut_in       = clut_ff;
      col_in        = col_ff;
      addr_in       = addr_ff;
      pend_in       = 1'b0;
      pend_addr_in  = addr_ff;
      rd_ok_in      = rd_ok_ff;
      res_colour_in = res_colour_ff;
      dirty_in      = dirty_ff;
      src_re        = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_colour_in = rsp_colour_ff;
      rsp_dirty_in  = rsp_dirty_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_colour_in = '0;
               rd_ok_in      = in_range;
               row_in        = '0;
               clut_in       = '0;
               col_in        = '0;
               addr_in       = '0;
               if (req_func == FUNC_APPLY) begin
                  state_in = ST_WALK;
               end else if (req_func == FUNC_READ) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_READ: begin
            res_colour_in = rd_ok_ff ? tint_rdata : '0;
            state_in      = ST_FIN;
         end
         ST_WALK: begin
            if (!row_ok) begin
               addr_in = addr_ff + ROW_STEP;
               clut_in = '0;
               col_in  = '0;
               if (end_row) begin
                  state_in = ST_DRAIN;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               if (clut_ok) begin
                  src_re       = 1'b1;
                  pend_in      = 1'b1;
                  pend_addr_in = addr_ff;
                  addr_in      = addr_ff + 1'b1;
               end else begin
                  addr_in = addr_ff + CLUT_STEP;
               end
               if (clut_ok && !end_col) begin
                  col_in = col_ff + 1'b1;
               end else begin
                  col_in = '0;
                  if (end_clut) begin
                     clut_in = '0;
                     if (end_row) begin
                        state_in = ST_DRAIN;
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                  end else begin
                     clut_in = clut_ff + 1'b1;
                  end
               end
            end
         end
         ST_DRAIN: begin
            dirty_in = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_colour_in = res_colour_ff;
               rsp_dirty_in  = dirty_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      row_mask_in  = row_mask_ff;
      clut_mask_in = clut_mask_ff;
      offsets_in   = offsets_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_ROW_MASK:  row_mask_in      = csr_data[ROW_MASK_W-1:0];
            REG_CLUT_MASK: clut_mask_in     = csr_data[CLUT_MASK_W-1:0];
            REG_RED_OFS:   offsets_in.red   = csr_data[OFFSET_W-1:0];
            REG_GREEN_OFS: offsets_in.green = csr_data[OFFSET_W-1:0];
            REG_BLUE_OFS:  offsets_in.blue  = csr_data[OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         dirty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         row_mask_ff  <= '0;
         clut_mask_ff <= '0;
         offsets_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
         row_mask_ff  <= row_mask_in;
         clut_mask_ff <= clut_mask_in;
         offsets_ff   <= offsets_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff        <= row_in;
      clut_ff       <= clut_in;
      col_ff        <= col_in;
      addr_ff       <= addr_in;
      pend_addr_ff  <= pend_addr_in;
      rd_ok_ff      <= rd_ok_in;
      res_colour_ff <= res_colour_in;
      rsp_colour_ff <= rsp_colour_in;
      rsp_dirty_ff  <= rsp_dirty_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_colour  = rsp_colour_ff;
   assign rsp_tinted_dirty = rsp_dirty_ff;

endmodule

// File: design/pte_checker.sv
// Port-level checks for the palette tint engine, bound to the top level.
module pte_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [pte_pkg::COLOUR_W-1:0]      rsp_read_colour,
   input logic                              rsp_tinted_dirty
);
   import pte_pkg::*;

   logic [1:0] outstanding_ff, outstanding_in;
   logic       seen_dirty_ff, seen_dirty_in;
   logic       req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      outstanding_in = outstanding_ff + 2'(req_fire) - 2'(rsp_fire);
      seen_dirty_in  = seen_dirty_ff || (rsp_fire && rsp_tinted_dirty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
         seen_dirty_ff  <= 1'b0;
      end else begin
         outstanding_ff <= outstanding_in;
         seen_dirty_ff  <= seen_dirty_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_read_colour) && $stable(rsp_tinted_dirty))
      else $error("stalled result word changed");

   a_dirty_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_dirty_ff |-> rsp_tinted_dirty)
      else $error("dirty flag dropped after an apply");

   a_in_flight: assert property (@(posedge clock) disable iff (reset)
      (outstanding_ff != 2'd3) && (!rsp_valid || outstanding_ff != 2'd0))
      else $error("result words out of step with request words");

endmodule

bind palette_tint_engine pte_checker u_pte_checker (.*);
